[rtl/gbmf_pkg.sv]
// Package for the grid-cell maximum feature detector.
// Constants, register indexes and the structs shared by the RTL files.
// No dependencies.
`timescale 1ns / 1ps

package gbmf_pkg;

  // Default sizing of the cell column store and the cell offsets
  localparam int MAX_CELLS_ACROSS_DEF = 64;
  localparam int MAX_CELL_SIZE_DEF    = 32;
  localparam int MAX_CELLS_DOWN       = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_ACROSS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_DOWN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_COLS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_ROWS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 3'd6;

  // Register reset values
  localparam logic [5:0] BLOCK_WIDTH_RST    = 6'd8;
  localparam logic [5:0] BLOCK_HEIGHT_RST   = 6'd8;
  localparam logic [6:0] BLOCKS_ACROSS_RST  = 7'd22;
  localparam logic [6:0] BLOCKS_DOWN_RST    = 7'd18;
  localparam logic [4:0] MARGIN_COLS_RST    = 5'd1;
  localparam logic [4:0] MARGIN_ROWS_RST    = 5'd1;
  localparam logic [7:0] THRESHOLD_RST      = 8'h18;

  // Feature counter saturates here
  localparam logic [12:0] COUNT_MAX = 13'h1fff;

  // Per-pixel control handed from the position tracker to the cell store
  typedef struct packed {
    logic        emit;      // last pixel of an in-margin cell
    logic        last;      // final in-margin cell of the frame
    logic        cnt_clr;   // pixel (0,0): feature count restarts
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [10:0] base_x;    // image x of the cell's first column
    logic [10:0] base_y;    // image y of the cell's first row
  } gbmf_ctl_t;

  // One result item
  typedef struct packed {
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [7:0]  strength;
    logic [10:0] point_x;
    logic [10:0] point_y;
    logic        is_feature;
    logic [12:0] feature_count;
    logic        last_cell;
  } gbmf_res_t;

endpackage

[rtl/gbmf_if.sv]
// Stream interfaces of the feature detector: pixel input and cell result output.
// Depends on gbmf_pkg for nothing but keeps the field widths of the item formats.
`timescale 1ns / 1ps

interface gbmf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface gbmf_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cell_col;
  logic [5:0]  cell_row;
  logic [7:0]  strength;
  logic [10:0] point_x;
  logic [10:0] point_y;
  logic        is_feature;
  logic [12:0] feature_count;
  logic        last_cell;

  modport source (output valid, output cell_col, output cell_row, output strength,
                  output point_x, output point_y, output is_feature,
                  output feature_count, output last_cell, input ready);
  modport sink   (input valid, input cell_col, input cell_row, input strength,
                  input point_x, input point_y, input is_feature,
                  input feature_count, input last_cell, output ready);
endinterface

[rtl/grid_block_max_feature_detect.sv]
// Grid-cell maximum feature detector. Takes one edge-magnitude pixel per clock in
// raster order while in_pix.ready is high. On the last pixel of each in-margin cell
// it offers one result on the output, through the cell store's stage register and
// a two-entry output queue that absorbs back-pressure. The per-column running
// maxima sit in a memory with one read and one write port: each pixel reads its
// column on transfer and writes it back when its stage moves on, with the write
// forwarded to a following pixel of the same column, so the sustained rate is one
// pixel per clock while the output queue has room. After reset and after every
// configuration write, in_pix.ready stays low while the geometry is loaded, the
// dividers take one step per bit of the position, the result is taken and the current
// pixel position is split again into cell index and offset for the new geometry.
// Depends on gbmf_pkg, gbmf_if, gbmf_div, gbmf_cell_store and gbmf_out_fifo.
`timescale 1ns / 1ps

module grid_block_max_feature_detect import gbmf_pkg::*; #(
  parameter int MAX_CELLS_ACROSS = MAX_CELLS_ACROSS_DEF,
  parameter int MAX_CELL_SIZE    = MAX_CELL_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gbmf_pix_if.sink              in_pix,
  gbmf_res_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SIZE_MAX   = (MAX_CELL_SIZE < 63) ? MAX_CELL_SIZE : 63;
  localparam int ACROSS_MAX = (MAX_CELLS_ACROSS < 127) ? MAX_CELLS_ACROSS : 127;
  localparam int CX_W       = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
  localparam int CY_W       = $clog2(MAX_CELLS_DOWN);
  localparam int OFF_W      = $clog2(SIZE_MAX);
  localparam int COL_W      = $clog2(SIZE_MAX * ACROSS_MAX);
  localparam int ROW_W      = $clog2(SIZE_MAX * MAX_CELLS_DOWN);
  localparam int IMGW_W     = COL_W + 1;
  localparam int IMGH_W     = ROW_W + 1;
  localparam int MW         = ((CX_W > 7) ? CX_W : 7) + 2;

  // 0 acts as 1, large values saturate
  function automatic logic [6:0] clamp_size(input logic [6:0] v, input logic [6:0] hi);
    return (v == 7'd0) ? 7'd1 : ((v > hi) ? hi : v);
  endfunction

  // Configuration registers
  logic [5:0] blk_w_r, blk_h_r;
  logic [6:0] blk_across_r, blk_down_r;
  logic [4:0] marg_c_r, marg_r_r;
  logic [7:0] thr_r;

  // Clamped geometry, loaded after reset and after each configuration write
  logic              geo_load_r;
  logic [5:0]        bw_r, bh_r;
  logic [6:0]        ba_r, bd_r;
  logic [IMGW_W-1:0] img_w_r;
  logic [IMGH_W-1:0] img_h_r;
  logic [6:0]        bw_c, bh_c, ba_c, bd_c;

  // Pixel position and its split into cell and offset
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [OFF_W-1:0] ox_r, oy_r;
  logic [CX_W-1:0]  cx_r;
  logic [CY_W-1:0]  cy_r;

  logic [COL_W-1:0] col, col_nxt;
  logic [ROW_W-1:0] row, row_nxt;
  logic [OFF_W-1:0] ox, oy, ox_nxt, oy_nxt;
  logic [CX_W-1:0]  cx, cx_nxt;
  logic [CY_W-1:0]  cy, cy_nxt;
  logic             restart;
  logic             cell_end;
  logic             in_margin;
  logic [MW-1:0]    mcx, mcy, mcol, mrow, macr, mdwn;
  gbmf_ctl_t        ctl;

  // Divider results
  logic             dc_busy, dc_done, dr_busy, dr_done;
  logic [COL_W-1:0] dc_quot;
  logic [ROW_W-1:0] dr_quot;
  logic [5:0]       dc_rem, dr_rem;

  // Handshake
  logic      sync_busy;
  logic      acc;
  logic      s1_vld, s1_emit, s1_go;
  logic      fifo_full;
  gbmf_res_t s1_res;
  gbmf_res_t out_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_w_r      <= BLOCK_WIDTH_RST;
      blk_h_r      <= BLOCK_HEIGHT_RST;
      blk_across_r <= BLOCKS_ACROSS_RST;
      blk_down_r   <= BLOCKS_DOWN_RST;
      marg_c_r     <= MARGIN_COLS_RST;
      marg_r_r     <= MARGIN_ROWS_RST;
      thr_r        <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BLOCK_WIDTH:    blk_w_r      <= cfg_data[5:0];
        CFG_BLOCK_HEIGHT:   blk_h_r      <= cfg_data[5:0];
        CFG_BLOCKS_ACROSS:  blk_across_r <= cfg_data[6:0];
        CFG_BLOCKS_DOWN:    blk_down_r   <= cfg_data[6:0];
        CFG_MARGIN_COLS:    marg_c_r     <= cfg_data[4:0];
        CFG_MARGIN_ROWS:    marg_r_r     <= cfg_data[4:0];
        CFG_EDGE_THRESHOLD: thr_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Geometry load: in the cycle after reset or a write, then re-split the position
  always_comb begin
    bw_c = clamp_size({1'b0, blk_w_r}, 7'(SIZE_MAX));
    bh_c = clamp_size({1'b0, blk_h_r}, 7'(SIZE_MAX));
    ba_c = clamp_size(blk_across_r, 7'(ACROSS_MAX));
    bd_c = clamp_size(blk_down_r, 7'(MAX_CELLS_DOWN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_load_r <= 1'b1;
    end else begin
      geo_load_r <= cfg_we;
    end
  end

  always_ff @(posedge clk) begin
    if (geo_load_r) begin
      bw_r    <= bw_c[5:0];
      bh_r    <= bh_c[5:0];
      ba_r    <= ba_c;
      bd_r    <= bd_c;
      img_w_r <= IMGW_W'(bw_c * ba_c);
      img_h_r <= IMGH_W'(bh_c * bd_c);
    end
  end

  gbmf_div #(.N_W(COL_W), .D_W(6)) u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (geo_load_r),
    .dividend (col_r),
    .divisor  (bw_c[5:0]),
    .busy     (dc_busy),
    .done     (dc_done),
    .quot     (dc_quot),
    .rem      (dc_rem)
  );

  gbmf_div #(.N_W(ROW_W), .D_W(6)) u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (geo_load_r),
    .dividend (row_r),
    .divisor  (bh_c[5:0]),
    .busy     (dr_busy),
    .done     (dr_done),
    .quot     (dr_quot),
    .rem      (dr_rem)
  );

  assign sync_busy = geo_load_r || dc_busy || dr_busy;

  // Position of the incoming pixel; a frame start or a stale position restarts at (0,0)
  always_comb begin
    restart = in_pix.frame_start || ({1'b0, col_r} >= img_w_r) ||
              ({1'b0, row_r} >= img_h_r);
    col = restart ? '0 : col_r;
    row = restart ? '0 : row_r;
    ox  = restart ? '0 : ox_r;
    oy  = restart ? '0 : oy_r;
    cx  = restart ? '0 : cx_r;
    cy  = restart ? '0 : cy_r;

    cell_end = (7'(ox) == 7'(bw_r) - 7'd1) && (7'(oy) == 7'(bh_r) - 7'd1);
    mcx  = MW'(cx);
    mcy  = MW'(cy);
    mcol = MW'(marg_c_r);
    mrow = MW'(marg_r_r);
    macr = MW'(ba_r);
    mdwn = MW'(bd_r);
    in_margin = (mcx >= mcol) && (mcx + mcol < macr) &&
                (mcy >= mrow) && (mcy + mrow < mdwn);

    ctl.emit     = cell_end && in_margin;
    ctl.last     = (mcx + mcol + MW'(1) == macr) && (mcy + mrow + MW'(1) == mdwn);
    ctl.cnt_clr  = (col == '0) && (row == '0);
    ctl.cell_col = 6'(cx);
    ctl.cell_row = 6'(cy);
    ctl.base_x   = 11'(col - COL_W'(ox));
    ctl.base_y   = 11'(row - ROW_W'(oy));

    // Advance in raster order
    col_nxt = col + COL_W'(1);
    row_nxt = row;
    ox_nxt  = ox + OFF_W'(1);
    oy_nxt  = oy;
    cx_nxt  = cx;
    cy_nxt  = cy;
    if (7'(ox) + 7'd1 == 7'(bw_r)) begin
      ox_nxt = '0;
      cx_nxt = cx + CX_W'(1);
    end
    if (IMGW_W'(col) + IMGW_W'(1) == img_w_r) begin
      col_nxt = '0;
      ox_nxt  = '0;
      cx_nxt  = '0;
      if (IMGH_W'(row) + IMGH_W'(1) == img_h_r) begin
        row_nxt = '0;
        oy_nxt  = '0;
        cy_nxt  = '0;
      end else begin
        row_nxt = row + ROW_W'(1);
        if (7'(oy) + 7'd1 == 7'(bh_r)) begin
          oy_nxt = '0;
          cy_nxt = cy + CY_W'(1);
        end else begin
          oy_nxt = oy + OFF_W'(1);
        end
      end
    end
  end

  // Position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ox_r  <= '0;
      oy_r  <= '0;
      cx_r  <= '0;
      cy_r  <= '0;
    end else begin
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        ox_r  <= ox_nxt;
        oy_r  <= oy_nxt;
        cx_r  <= cx_nxt;
        cy_r  <= cy_nxt;
      end else begin
        // re-split after a geometry load
        if (dc_done) begin
          cx_r <= CX_W'(dc_quot);
          ox_r <= OFF_W'(dc_rem);
        end
        if (dr_done) begin
          cy_r <= CY_W'(dr_quot);
          oy_r <= OFF_W'(dr_rem);
        end
      end
    end
  end

  // Transfer control
  assign s1_go        = s1_vld && (!s1_emit || !fifo_full);
  assign in_pix.ready = !sync_busy && (!s1_vld || s1_go);
  assign acc          = in_pix.valid && in_pix.ready;

  gbmf_cell_store #(
    .DEPTH (MAX_CELLS_ACROSS),
    .CX_W  (CX_W),
    .OFF_W (OFF_W)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .addr  (cx),
    .first ((ox == '0) && (oy == '0)),
    .pix   (in_pix.pixel),
    .off_x (ox),
    .off_y (oy),
    .ctl   (ctl),
    .go    (s1_go),
    .thr   (thr_r),
    .vld   (s1_vld),
    .emit  (s1_emit),
    .res   (s1_res)
  );

  gbmf_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_go && s1_emit),
    .din       (s1_res),
    .full      (fifo_full),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .dout      (out_data)
  );

  // Result channel payload
  assign out_res.cell_col      = out_data.cell_col;
  assign out_res.cell_row      = out_data.cell_row;
  assign out_res.strength      = out_data.strength;
  assign out_res.point_x       = out_data.point_x;
  assign out_res.point_y       = out_data.point_y;
  assign out_res.is_feature    = out_data.is_feature;
  assign out_res.feature_count = out_data.feature_count;
  assign out_res.last_cell     = out_data.last_cell;

endmodule

[rtl/gbmf_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used to split the pixel position into cell index and offset. No dependencies.
`timescale 1ns / 1ps

module gbmf_div #(
  parameter int N_W = 11,
  parameter int D_W = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quot,
  output logic [D_W-1:0] rem
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [N_W-1:0]   quo_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   div_r;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             take;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_r, quo_r[N_W-1]};
    diff  = trial - {1'b0, div_r};
    take  = (trial >= {1'b0, div_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(N_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[N_W-2:0], take};
      rem_r <= take ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign busy = (cnt_r != '0) || done_r;
  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

[rtl/gbmf_cell_store.sv]
// Per-column cell maximum store: memory, read-modify-write stage, feature count.
// Depends on gbmf_pkg (gbmf_ctl_t, gbmf_res_t, COUNT_MAX).
`timescale 1ns / 1ps

module gbmf_cell_store import gbmf_pkg::*; #(
  parameter int DEPTH = MAX_CELLS_ACROSS_DEF,
  parameter int CX_W  = 6,
  parameter int OFF_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [CX_W-1:0]  addr,
  input  logic             first,
  input  logic [7:0]       pix,
  input  logic [OFF_W-1:0] off_x,
  input  logic [OFF_W-1:0] off_y,
  input  gbmf_ctl_t        ctl,
  input  logic             go,
  input  logic [7:0]       thr,
  output logic             vld,
  output logic             emit,
  output gbmf_res_t        res
);

  typedef struct packed {
    logic [7:0]       mx;
    logic [OFF_W-1:0] ox;
    logic [OFF_W-1:0] oy;
  } ent_t;

  ent_t             cell_mem [DEPTH];
  logic [DEPTH-1:0] vbit_r;

  logic             vld_r;
  logic [12:0]      found_r;
  logic [CX_W-1:0]  addr_r;
  logic             first_r;
  logic [7:0]       pix_r;
  logic [OFF_W-1:0] off_x_r;
  logic [OFF_W-1:0] off_y_r;
  gbmf_ctl_t        ctl_r;
  ent_t             rd_r;
  logic             rdv_r;
  logic             fwd_r;
  ent_t             fwd_ent_r;

  ent_t             old_ent;
  ent_t             base_ent;
  ent_t             new_ent;
  logic             feat;
  logic [12:0]      cnt_base;
  logic [12:0]      cnt_new;

  // Update of the running maximum; the previous item's write-back is forwarded
  always_comb begin
    old_ent  = fwd_r ? fwd_ent_r : (rdv_r ? rd_r : '0);
    base_ent = first_r ? '0 : old_ent;
    if (pix_r > base_ent.mx) begin
      new_ent.mx = pix_r;
      new_ent.ox = off_x_r;
      new_ent.oy = off_y_r;
    end else begin
      new_ent = base_ent;
    end
    feat     = (new_ent.mx > thr);
    cnt_base = ctl_r.cnt_clr ? '0 : found_r;
    cnt_new  = (ctl_r.emit && feat && (cnt_base != COUNT_MAX)) ?
               cnt_base + 13'd1 : cnt_base;
  end

  // Result of a finished cell
  always_comb begin
    res.cell_col      = ctl_r.cell_col;
    res.cell_row      = ctl_r.cell_row;
    res.strength      = feat ? new_ent.mx : 8'd0;
    res.point_x       = ctl_r.base_x + 11'(new_ent.ox);
    res.point_y       = ctl_r.base_y + 11'(new_ent.oy);
    res.is_feature    = feat;
    res.feature_count = cnt_new;
    res.last_cell     = ctl_r.last;
  end

  assign vld  = vld_r;
  assign emit = vld_r && ctl_r.emit;

  // Memory: read on transfer, write back when the stage moves on
  always_ff @(posedge clk) begin
    if (go) begin
      cell_mem[addr_r] <= new_ent;
    end
    if (acc) begin
      rd_r <= cell_mem[addr];
    end
  end

  // Stage control, valid bits and feature count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      found_r <= '0;
      vbit_r  <= '0;
    end else begin
      if (acc) begin
        vld_r <= 1'b1;
      end else if (go) begin
        vld_r <= 1'b0;
      end
      if (go) begin
        found_r        <= cnt_new;
        vbit_r[addr_r] <= 1'b1;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      addr_r    <= addr;
      first_r   <= first;
      pix_r     <= pix;
      off_x_r   <= off_x;
      off_y_r   <= off_y;
      ctl_r     <= ctl;
      rdv_r     <= vbit_r[addr];
      fwd_r     <= go && (addr_r == addr);
      fwd_ent_r <= new_ent;
    end
  end

endmodule

[rtl/gbmf_out_fifo.sv]
// Two-entry result queue between the cell store and the output channel.
// Depends on gbmf_pkg (gbmf_res_t).
`timescale 1ns / 1ps

module gbmf_out_fifo import gbmf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  gbmf_res_t din,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output gbmf_res_t dout
);

  gbmf_res_t   ent_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign dout      = ent_r[rp_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

endmodule

[tb/grid_block_max_feature_detect_test.sv]
// Self-checking testbench for grid_block_max_feature_detect.
// Drives pixels in raster order and predicts every cell result in step with the inputs.
// Depends on rtl/gbmf_pkg.sv, rtl/gbmf_if.sv and the block's RTL.
`timescale 1ns / 1ps

module grid_block_max_feature_detect_test;
  import gbmf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PIXELS = 1225;
  localparam int unsigned MAX_RUN       = 400;
  localparam int unsigned DRAIN_CYCLES  = 6;
  localparam int unsigned REPORT_LIMIT  = 10;
  // index 7 is not mapped to any register
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gbmf_pix_if pix_ch ();
  gbmf_res_if res_ch ();

  grid_block_max_feature_detect dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_res (res_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // Idle percentages for the two sides of the stream
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Shadow copy of the registers
  logic [5:0] bw_reg, bh_reg;
  logic [6:0] ba_reg, bd_reg;
  logic [4:0] mc_reg, mr_reg;
  logic [7:0] thr_reg;

  // Per-column running maxima, raster position and feature tally
  logic [7:0]  col_max   [MAX_CELLS_ACROSS_DEF];
  logic [4:0]  col_off_x [MAX_CELLS_ACROSS_DEF];
  logic [4:0]  col_off_y [MAX_CELLS_ACROSS_DEF];
  int unsigned at_col, at_row, feat_found;

  gbmf_res_t   due_cells[$];
  int unsigned error_count, checked_count, pixel_count, setting_count, cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count, due_cells.size());
      $display("grid_block_max_feature_detect_test: FAIL");
      $finish;
    end
  end

  function automatic int unsigned clip_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned frame_pixels();
    return clip_size(bw_reg, MAX_CELL_SIZE_DEF) * clip_size(ba_reg, MAX_CELLS_ACROSS_DEF) *
           clip_size(bh_reg, MAX_CELL_SIZE_DEF) * clip_size(bd_reg, MAX_CELLS_DOWN);
  endfunction

  // Advance the cell tracker by one accepted pixel; queue the cell result it finishes
  function automatic void track_pixel(input logic [7:0] pix, input logic fs);
    int unsigned bw, bh, ba, bd, img_w, img_h, cx, cy, ox, oy;
    bit          feat;
    gbmf_res_t   due;
    bw = clip_size(bw_reg, MAX_CELL_SIZE_DEF);
    bh = clip_size(bh_reg, MAX_CELL_SIZE_DEF);
    ba = clip_size(ba_reg, MAX_CELLS_ACROSS_DEF);
    bd = clip_size(bd_reg, MAX_CELLS_DOWN);
    img_w = bw * ba;
    img_h = bh * bd;
    // frame start, or a position left outside a shrunken image, restarts at the origin
    if (fs || at_col >= img_w || at_row >= img_h) begin
      at_col = 0;
      at_row = 0;
    end
    if (at_col == 0 && at_row == 0) feat_found = 0;
    cx = at_col / bw;
    ox = at_col % bw;
    cy = at_row / bh;
    oy = at_row % bh;
    if (cx >= MAX_CELLS_ACROSS_DEF) cx = MAX_CELLS_ACROSS_DEF - 1;
    // first pixel of a cell: search starts from zero at offset (0,0)
    if (ox == 0 && oy == 0) begin
      col_max[cx]   = 8'd0;
      col_off_x[cx] = 5'd0;
      col_off_y[cx] = 5'd0;
    end
    // strictly greater, so ties keep the earliest pixel
    if (pix > col_max[cx]) begin
      col_max[cx]   = pix;
      col_off_x[cx] = 5'(ox);
      col_off_y[cx] = 5'(oy);
    end
    if (ox == bw - 1 && oy == bh - 1 && cx >= mc_reg && cx + mc_reg < ba &&
        cy >= mr_reg && cy + mr_reg < bd) begin
      feat = col_max[cx] > thr_reg;
      if (feat && feat_found < COUNT_MAX) feat_found++;
      due.cell_col      = 6'(cx);
      due.cell_row      = 6'(cy);
      due.strength      = feat ? col_max[cx] : 8'd0;
      due.point_x       = 11'(cx * bw + col_off_x[cx]);
      due.point_y       = 11'(cy * bh + col_off_y[cx]);
      due.is_feature    = feat;
      due.feature_count = 13'(feat_found);
      due.last_cell     = (cx + mc_reg + 1 == ba) && (cy + mr_reg + 1 == bd);
      due_cells.push_back(due);
    end
    at_col++;
    if (at_col >= img_w) begin
      at_col = 0;
      at_row++;
      if (at_row >= img_h) at_row = 0;
    end
  endfunction

  function automatic string show_cell(input gbmf_res_t c);
    return $sformatf("cell(%0d,%0d) str=%0d pt=(%0d,%0d) feat=%0b cnt=%0d last=%0b",
                     c.cell_col, c.cell_row, c.strength, c.point_x, c.point_y,
                     c.is_feature, c.feature_count, c.last_cell);
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Compare one transferred result with the oldest expectation
  function automatic void check_cell();
    gbmf_res_t got, want;
    string     diff;
    got.cell_col      = res_ch.cell_col;
    got.cell_row      = res_ch.cell_row;
    got.strength      = res_ch.strength;
    got.point_x       = res_ch.point_x;
    got.point_y       = res_ch.point_y;
    got.is_feature    = res_ch.is_feature;
    got.feature_count = res_ch.feature_count;
    got.last_cell     = res_ch.last_cell;
    if (due_cells.size() == 0) begin
      note_error($sformatf("result with nothing due: %s", show_cell(got)));
      return;
    end
    want = due_cells.pop_front();
    diff = "";
    if (got.cell_col !== want.cell_col) diff = {diff, " cell_col"};
    if (got.cell_row !== want.cell_row) diff = {diff, " cell_row"};
    if (got.strength !== want.strength) diff = {diff, " strength"};
    if (got.point_x !== want.point_x) diff = {diff, " point_x"};
    if (got.point_y !== want.point_y) diff = {diff, " point_y"};
    if (got.is_feature !== want.is_feature) diff = {diff, " is_feature"};
    if (got.feature_count !== want.feature_count) diff = {diff, " feature_count"};
    if (got.last_cell !== want.last_cell) diff = {diff, " last_cell"};
    if (diff != "") begin
      note_error($sformatf("mismatch in%s: expected %s, got %s", diff, show_cell(want),
                           show_cell(got)));
    end else begin
      checked_count++;
    end
  endfunction

  // Result checker, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) check_cell();
  end

  // Result receiver with random back-pressure
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One pixel transfer; entered and left at a falling edge, valid left high
  task automatic send_pixel(input logic [7:0] pix, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= pix;
    pix_ch.frame_start <= fs;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    track_pixel(pix, fs);
    pixel_count++;
    @(negedge clk);
  endtask

  // Stop sending and let every due result arrive, plus the pipeline tail
  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    while (due_cells.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write; waits for the block to take pixels again afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BLOCK_WIDTH:    bw_reg  = val[5:0];
      CFG_BLOCK_HEIGHT:   bh_reg  = val[5:0];
      CFG_BLOCKS_ACROSS:  ba_reg  = val[6:0];
      CFG_BLOCKS_DOWN:    bd_reg  = val[6:0];
      CFG_MARGIN_COLS:    mc_reg  = val[4:0];
      CFG_MARGIN_ROWS:    mr_reg  = val[4:0];
      CFG_EDGE_THRESHOLD: thr_reg = val;
      default: ;
    endcase
    repeat (2) @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [7:0] bw, input logic [7:0] bh, input logic [7:0] ba,
                              input logic [7:0] bd, input logic [7:0] mc, input logic [7:0] mr,
                              input logic [7:0] thr);
    write_reg(CFG_BLOCK_WIDTH, bw);
    write_reg(CFG_BLOCK_HEIGHT, bh);
    write_reg(CFG_BLOCKS_ACROSS, ba);
    write_reg(CFG_BLOCKS_DOWN, bd);
    write_reg(CFG_MARGIN_COLS, mc);
    write_reg(CFG_MARGIN_ROWS, mr);
    write_reg(CFG_EDGE_THRESHOLD, thr);
    setting_count++;
  endtask

  // Reset geometry: a few pixels, far from any cell end, then the unmapped index
  task automatic test_reset_defaults();
    send_pixel(8'hff, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h5a, 1'b0);
    wait_idle();
    write_reg(CFG_UNMAPPED, 8'ha5);
  endtask

  // All sizes written as zero act as one: every pixel is a whole frame.
  // The old position lies outside the new image, so the first pixel restarts.
  task automatic test_unit_geometry();
    set_geometry(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'hff, 1'b0);
    wait_idle();
  endtask

  // 2x1 cells, 3x2 grid, one margin column: equal values keep the first,
  // and a maximum equal to the threshold is not a feature
  task automatic test_ties_and_threshold();
    logic [7:0] frame_pix [12];
    frame_pix = '{8'hff, 8'h10, 8'h28, 8'h28, 8'h00, 8'h30,
                  8'h00, 8'h00, 8'h00, 8'h29, 8'h01, 8'h00};
    set_geometry(8'd2, 8'd1, 8'd3, 8'd2, 8'd1, 8'd0, 8'h28);
    foreach (frame_pix[i]) send_pixel(frame_pix[i], i == 0);
    wait_idle();
  endtask

  // Frame start mid-frame restarts the raster; then margins that leave no cell
  task automatic test_restart_and_margins();
    send_pixel(8'h77, 1'b1);
    send_pixel(8'h33, 1'b0);
    send_pixel(8'h90, 1'b1);
    wait_idle();
    // upper bits beyond the field are dropped: margin of 2 on a 3-cell row
    write_reg(CFG_MARGIN_COLS, 8'he2);
    send_pixel(8'hc0, 1'b0);
    send_pixel(8'hfe, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7f, 1'b0);
    wait_idle();
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      2: return thr_reg;
      3: return thr_reg + 8'd1;
      4: return 8'h40;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random register set, mostly small grids, a few at the saturating sizes
  task automatic pick_geometry();
    logic [7:0] bw, bh, ba, bd, mc, mr, thr;
    int unsigned kind;
    kind = $urandom_range(9);
    bw = 8'($urandom_range(1, 4));
    bh = 8'($urandom_range(1, 4));
    ba = 8'($urandom_range(1, 6));
    bd = 8'($urandom_range(1, 5));
    if (kind == 7) begin
      // widest or tallest cells; the field saturates at the cell size limit
      if ($urandom_range(1)) begin
        bw = 8'($urandom_range(32, 63) | ($urandom_range(3) << 6));
        bh = 8'($urandom_range(1, 2));
        ba = 8'($urandom_range(1, 3));
        bd = 8'($urandom_range(1, 2));
      end else begin
        bw = 8'd1;
        bh = 8'($urandom_range(32, 63) | ($urandom_range(3) << 6));
        ba = 8'($urandom_range(1, 2));
        bd = 8'd1;
      end
    end else if (kind == 8) begin
      // as many cell columns as the column store holds
      bw = 8'd1;
      bh = 8'd1;
      ba = 8'($urandom_range(64, 127) | ($urandom_range(1) << 7));
      bd = 8'($urandom_range(1, 2));
    end else if (kind == 9) begin
      // as many cell rows as allowed
      bw = 8'd1;
      bh = 8'd1;
      ba = 8'($urandom_range(1, 2));
      bd = 8'($urandom_range(64, 127) | ($urandom_range(1) << 7));
    end else begin
      // size of one may be written as zero; junk above the field width
      if (bw == 1 && $urandom_range(3) == 0) bw = 8'd0;
      if (ba == 1 && $urandom_range(3) == 0) ba = 8'd0;
      bw = bw | 8'($urandom_range(3) << 6);
      bh = bh | 8'($urandom_range(3) << 6);
      ba = ba | 8'($urandom_range(1) << 7);
    end
    mc = ($urandom_range(4) == 0) ? 8'($urandom_range(31)) : 8'($urandom_range(2));
    mr = ($urandom_range(4) == 0) ? 8'($urandom_range(31)) : 8'($urandom_range(2));
    mc = mc | 8'($urandom_range(7) << 5);
    mr = mr | 8'($urandom_range(7) << 5);
    case ($urandom_range(9))
      0, 1: thr = 8'h00;
      2:    thr = 8'hff;
      default: thr = 8'($urandom_range(255));
    endcase
    set_geometry(bw, bh, ba, bd, mc, mr, thr);
  endtask

  // Runs of whole frames with random content, some cut short or restarted
  task automatic test_random_frames();
    int unsigned sent, run_len;
    logic        fs;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if (sent < RANDOM_PIXELS / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 74;
      end else if (sent < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_geometry();
      run_len = frame_pixels() * $urandom_range(1, 2);
      if ($urandom_range(3) == 0) run_len = $urandom_range(1, run_len);
      if (run_len > MAX_RUN) run_len = MAX_RUN;
      if (run_len > RANDOM_PIXELS - sent) run_len = RANDOM_PIXELS - sent;
      repeat (run_len) begin
        if (at_col == 0 && at_row == 0) fs = ($urandom_range(9) != 0);
        else fs = ($urandom_range(49) == 0);
        send_pixel(pick_pixel(), fs);
        sent++;
      end
      wait_idle();
    end
  endtask

  // Sequence of tests
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = 8'h00;
    pix_ch.frame_start = 1'b0;
    bw_reg  = BLOCK_WIDTH_RST;
    bh_reg  = BLOCK_HEIGHT_RST;
    ba_reg  = BLOCKS_ACROSS_RST;
    bd_reg  = BLOCKS_DOWN_RST;
    mc_reg  = MARGIN_COLS_RST;
    mr_reg  = MARGIN_ROWS_RST;
    thr_reg = THRESHOLD_RST;
    foreach (col_max[i]) begin
      col_max[i]   = 8'd0;
      col_off_x[i] = 5'd0;
      col_off_y[i] = 5'd0;
    end
    at_col        = 0;
    at_row        = 0;
    feat_found    = 0;
    error_count   = 0;
    checked_count = 0;
    pixel_count   = 0;
    setting_count = 1;
    cycle_count   = 0;
    send_idle_pct = 38;
    recv_idle_pct = 74;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_unit_geometry();
    test_ties_and_threshold();
    test_restart_and_margins();
    test_random_frames();

    wait_idle();
    $display("Covered %0d pixels over %0d register settings; %0d cell results matched.",
             pixel_count, setting_count, checked_count);
    $display("Back-pressure ran 38/74 and 74/38 percent idle, then none; %0d errors.",
             error_count);
    if (error_count == 0) begin
      $display("grid_block_max_feature_detect_test: PASS");
    end else begin
      $display("grid_block_max_feature_detect_test: FAIL");
    end
    $finish;
  end

endmodule
